// ===== rtl/kci_pkg.sv =====
// Shared types and constants for the keyframe camera interpolator.
// No dependencies.
`default_nettype none
package kci_pkg;

  localparam int NUM_VALUES = 12;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_SET     = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_CYCLE   = 2'd0,
    REG_REVERSE = 2'd1,
    REG_COUNT   = 2'd2
  } reg_e;

  localparam logic [3:0] CHAN_TIME = 4'd0;
  localparam logic [3:0] CHAN_LAST = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_WDIV,
    ST_CHK,
    ST_SRD,
    ST_SCMP,
    ST_SEG,
    ST_SEGA,
    ST_SEGB,
    ST_TDIV,
    ST_LA,
    ST_LB,
    ST_LC,
    ST_LMUL,
    ST_FIN
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/keyframe_camera_interpolator.sv =====
// Keyframe camera interpolator: key tables, key search, lerp of twelve channels.
// Depends on kci_pkg, kci_div and kci_mul.
// A load word is written straight to the key tables; a time word runs a wrap divide (only when
// cycling wraps the time), the key search, a segment divide (only when the segment has nonzero
// length) and one multiply per channel before out_valid_o.
// Takes one word at a time (in_ready_o only when idle); a finished result waits in the output register.
// Reset clears control state, time and maximum and sets the key count to 1; key tables are undefined until loaded.
`default_nettype none
module keyframe_camera_interpolator import kci_pkg::*; #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [5:0]         key_slot_i,
  input  logic [3:0]         channel_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] target_x_o,
  output logic signed [31:0] target_y_o,
  output logic signed [31:0] target_z_o,
  output logic signed [31:0] up_x_o,
  output logic signed [31:0] up_y_o,
  output logic signed [31:0] up_z_o,
  output logic [30:0]        near_plane_o,
  output logic signed [31:0] far_plane_o,
  output logic signed [31:0] view_angle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);

  localparam int KW  = $clog2(MAX_KEYS);
  localparam int CKW = KW + 1;
  localparam int LW  = CKW + 1;
  localparam int VD  = MAX_KEYS * NUM_VALUES;
  localparam int VAW = $clog2(VD);
  localparam int DNW = 33 + FRAC_BITS;
  localparam int DDW = 33;
  localparam int PW  = 65;
  localparam logic signed [31:0] T_ONE    = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] NEAR_MIN = 32'((2 ** FRAC_BITS + 9999) / 10000);
  localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'(S32_MAX)) r = S32_MAX;
    else if (v < 68'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [KW-1:0] src_key(input logic [CKW-1:0] k, input logic [LW-1:0] n);
    logic [LW-1:0] kk;
    logic [KW-1:0] r;
    kk = LW'(k);
    if (kk < n) r = KW'(kk);
    else r = KW'((n << 1) - LW'(1) - kk);
    return r;
  endfunction

  function automatic logic signed [31:0] time_at(input logic [CKW-1:0] k,
                                                 input logic [LW-1:0] n,
                                                 input logic signed [31:0] rd,
                                                 input logic signed [31:0] mx);
    logic signed [31:0] r;
    if (LW'(k) < n) r = rd;
    else r = sat32((68'(mx) <<< 1) - 68'(rd));
    return r;
  endfunction

  function automatic logic [VAW-1:0] vaddr(input logic [KW-1:0] s, input logic [3:0] ch);
    logic [31:0] a;
    a = 32'(s) * 32'(NUM_VALUES) + 32'(ch);
    return a[VAW-1:0];
  endfunction

  state_e state_q, state_d;

  logic               cycle_q, reverse_q;
  logic [6:0]         key_count_q;
  logic signed [31:0] max_q, time_q, tk_q, t_q, a_q;
  logic [CKW-1:0]     key_q, nxt_q;
  logic [3:0]         ch_q;
  logic               neg_q;
  logic signed [31:0] res_q [NUM_VALUES];
  logic signed [31:0] out_q [NUM_VALUES];
  logic               out_valid_q, out_valid_d, fin_go;

  logic signed [31:0] kt_mem [MAX_KEYS];
  logic signed [31:0] kv_mem [VD];
  logic signed [31:0] kt_rd_q, kv_rd_q;
  logic [KW-1:0]      kt_raddr;
  logic [VAW-1:0]     kv_raddr;

  logic [LW-1:0]      n_keys, list_len, key_p1;
  logic signed [31:0] total, t_search, t_cur, t_nxt;
  logic               has_next, do_wrap, in_acc, load_ok;
  logic [31:0]        slot_ext;

  logic               div_start, div_done;
  logic [DNW-1:0]     div_num, div_quot;
  logic [DDW-1:0]     div_den, div_rem;
  logic signed [32:0] seg_num, seg_den;
  logic               mul_start, mul_done;
  logic signed [32:0] mul_a;
  logic [PW-1:0]      mul_prod;
  logic signed [31:0] t_div, lerp_v;
  logic               q_big;

  always_comb begin
    if (key_count_q == 7'd0) n_keys = LW'(1);
    else if (32'(key_count_q) > 32'(MAX_KEYS)) n_keys = LW'(MAX_KEYS);
    else n_keys = LW'(key_count_q);
    list_len = reverse_q ? (n_keys << 1) : n_keys;
    total    = reverse_q ? sat32(68'(max_q) <<< 1) : max_q;
    key_p1   = LW'(key_q) + LW'(1);
    has_next = key_p1 < list_len;
    do_wrap  = cycle_q && (total > 32'sd0) && (time_q > total);
    t_search = time_at(CKW'(key_p1), n_keys, kt_rd_q, max_q);
    t_cur    = time_at(key_q, n_keys, kt_rd_q, max_q);
    t_nxt    = time_at(nxt_q, n_keys, kt_rd_q, max_q);
    seg_num  = 33'(time_q) - 33'(tk_q);
    seg_den  = 33'(t_nxt) - 33'(tk_q);
    mul_a    = 33'(kv_rd_q) - 33'(a_q);
    q_big    = |div_quot[DNW-1:32];
    if (neg_q) begin
      t_div = (q_big || (div_quot[31] && |div_quot[30:0])) ? S32_MIN : -$signed(div_quot[31:0]);
    end else begin
      t_div = (q_big || div_quot[31]) ? S32_MAX : $signed(div_quot[31:0]);
    end
    lerp_v   = sat32(68'(a_q) + 68'($signed(mul_prod) >>> FRAC_BITS));
    slot_ext = 32'(key_slot_i);
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign load_ok     = in_acc && (cmd_i == CMD_LOAD) && (slot_ext < 32'(MAX_KEYS))
                       && (channel_i <= CHAN_LAST);
  assign fin_go      = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_d = fin_go || (out_valid_q && !out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_i)
            CMD_ADVANCE, CMD_SET: state_d = ST_WRAP;
            CMD_RESET:            state_d = ST_SEG;
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRAP: state_d = do_wrap ? ST_WDIV : ST_CHK;
      ST_WDIV: if (div_done) state_d = ST_CHK;
      ST_CHK:  state_d = ST_SRD;
      ST_SRD:  state_d = has_next ? ST_SCMP : ST_SEG;
      ST_SCMP: state_d = (time_q > t_search) ? ST_SRD : ST_SEG;
      ST_SEG:  state_d = has_next ? ST_SEGA : ST_LA;
      ST_SEGA: state_d = ST_SEGB;
      ST_SEGB: state_d = (t_nxt == tk_q) ? ST_LA : ST_TDIV;
      ST_TDIV: if (div_done) state_d = ST_LA;
      ST_LA:   state_d = ST_LB;
      ST_LB:   state_d = ST_LC;
      ST_LC:   state_d = ST_LMUL;
      ST_LMUL: if (mul_done) state_d = (ch_q == 4'(NUM_VALUES - 1)) ? ST_FIN : ST_LA;
      ST_FIN:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    kt_raddr  = src_key(key_q, n_keys);
    kv_raddr  = vaddr(src_key(key_q, n_keys), ch_q);
    div_start = 1'b0;
    div_num   = DNW'(32'(time_q) - 32'd1);
    div_den   = DDW'(total);
    mul_start = 1'b0;
    case (state_q)
      ST_WRAP: div_start = do_wrap;
      ST_SRD:  kt_raddr  = src_key(CKW'(key_p1), n_keys);
      ST_SEGA: kt_raddr  = src_key(nxt_q, n_keys);
      ST_SEGB: begin
        div_start = t_nxt != tk_q;
        div_num   = {33'(seg_num[32] ? -seg_num : seg_num), {FRAC_BITS{1'b0}}};
        div_den   = 33'(seg_den[32] ? -seg_den : seg_den);
      end
      ST_LB:   kv_raddr  = vaddr(src_key(nxt_q, n_keys), ch_q);
      ST_LC:   mul_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cycle_q     <= 1'b0;
      reverse_q   <= 1'b0;
      key_count_q <= 7'd1;
      max_q       <= '0;
      time_q      <= '0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_CYCLE:   cycle_q     <= cfg_data_i[0];
          REG_REVERSE: reverse_q   <= cfg_data_i[0];
          REG_COUNT:   key_count_q <= cfg_data_i;
          default:     ;
        endcase
      end
      if (load_ok && (channel_i == CHAN_TIME) && (value_i > max_q)) max_q <= value_i;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (cmd_i)
              CMD_ADVANCE: time_q <= sat32(68'(time_q) + 68'(value_i));
              CMD_SET: begin
                time_q <= value_i;
                key_q  <= '0;
              end
              CMD_RESET: begin
                time_q <= '0;
                key_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_WDIV: begin
          if (div_done) begin
            time_q <= $signed(div_rem[31:0]) + 32'sd1;
            key_q  <= '0;
          end
        end
        ST_CHK:  if (LW'(key_q) >= list_len) key_q <= '0;
        ST_SCMP: if (time_q > t_search) key_q <= CKW'(key_p1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SEG: begin
        nxt_q <= has_next ? CKW'(key_p1) : key_q;
        t_q   <= T_ONE;
        ch_q  <= '0;
      end
      ST_SEGA: tk_q <= t_cur;
      ST_SEGB: neg_q <= seg_num[32] ^ seg_den[32];
      ST_TDIV: if (div_done) t_q <= t_div;
      ST_LB:   a_q <= kv_rd_q;
      ST_LMUL: begin
        if (mul_done) begin
          res_q[ch_q] <= lerp_v;
          ch_q        <= ch_q + 4'd1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          for (int i = 0; i < 3; i++) begin
            out_q[i]     <= res_q[i];
            out_q[3 + i] <= sat32(68'(res_q[6 + i]) + 68'(res_q[i]));
            out_q[6 + i] <= res_q[3 + i];
          end
          out_q[9]  <= (res_q[9] < NEAR_MIN) ? NEAR_MIN : res_q[9];
          out_q[10] <= res_q[10];
          out_q[11] <= res_q[11];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && (channel_i == CHAN_TIME)) kt_mem[slot_ext[KW-1:0]] <= value_i;
    kt_rd_q <= kt_mem[kt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && (channel_i != CHAN_TIME)) begin
      kv_mem[vaddr(slot_ext[KW-1:0], channel_i - 4'd1)] <= value_i;
    end
    kv_rd_q <= kv_mem[kv_raddr];
  end

  kci_div #(.NW(DNW), .DW(DDW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  kci_mul #(.AW(33), .BW(32)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (t_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign out_valid_o  = out_valid_q;
  assign pos_x_o      = out_q[0];
  assign pos_y_o      = out_q[1];
  assign pos_z_o      = out_q[2];
  assign target_x_o   = out_q[3];
  assign target_y_o   = out_q[4];
  assign target_z_o   = out_q[5];
  assign up_x_o       = out_q[6];
  assign up_y_o       = out_q[7];
  assign up_z_o       = out_q[8];
  assign near_plane_o = out_q[9][30:0];
  assign far_plane_o  = out_q[10];
  assign view_angle_o = out_q[11];

`ifndef ASSERT_OFF
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WDIV || state_q == ST_TDIV))
    else $error("divider finished outside a divide state");
  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_LMUL)
    else $error("multiplier finished outside the lerp wait");
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LA |-> (LW'(key_q) < list_len && LW'(nxt_q) < list_len))
    else $error("current key outside key list");
  a_near_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(near_plane_o) >= NEAR_MIN)
    else $error("near plane below clamp");
`endif

endmodule
`default_nettype wire

// ===== rtl/kci_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by the keyframe camera interpolator.
`default_nettype none
module kci_div #(
  parameter int NW = 49,
  parameter int DW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, den_q;
  logic [DW:0]   shifted;
  logic          ge;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/kci_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Standalone; used by the keyframe camera interpolator.
`default_nettype none
module kci_mul #(
  parameter int AW = 33,
  parameter int BW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic                 done_o,
  output logic [AW+BW-1:0]     prod_o
);

  localparam int HW = AW + 2;
  localparam int CW = $clog2(BW);

  logic                 busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic signed [HW-1:0] hi_q, addend, sum;
  logic signed [AW-1:0] a_q;
  logic [BW-1:0]        lo_q;
  logic                 last;

  assign last = cnt_q == CW'(BW - 1);

  always_comb begin
    addend = '0;
    if (lo_q[0]) begin
      addend = last ? -HW'(a_q) : HW'(a_q);
    end
    sum = hi_q + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      a_q  <= a_i;
    end else if (busy_q) begin
      hi_q <= sum >>> 1;
      lo_q <= {sum[0], lo_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[AW-1:0], lo_q};

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for keyframe_camera_interpolator: directed table plus random words,
// checked against an in-bench camera predictor or typed expected cameras. Depends on kci_pkg and the RTL top level.
// Random idling on both channels; a cycle counter bounds the run.
`default_nettype none
module testbench;
  import kci_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  MAXK        = 64;
  localparam int  FRAC        = 16;
  localparam longint ONE      = longint'(1) << FRAC;
  localparam longint NEAR_LOW = (ONE + 9999) / 10000;
  localparam longint LIMIT    = 15_000_000;
  localparam int  DRAIN       = 3000;

  typedef logic [11:0][31:0] cam_t;

  typedef struct {
    cmd_e        cmd;
    logic [5:0]  slot;
    logic [3:0]  chan;
    logic [31:0] val;
    bit          typed;
    cam_t        cam;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [1:0] cmd, cfg_index;
  logic [5:0] key_slot;
  logic [3:0] channel;
  logic signed [31:0] value;
  logic [6:0] cfg_data;
  logic signed [31:0] pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z, up_x, up_y, up_z;
  logic signed [31:0] far_pl, fov;
  logic [30:0] near_pl;

  keyframe_camera_interpolator i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .key_slot_i(key_slot), .channel_i(channel), .value_i(value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .pos_z_o(pos_z),
    .target_x_o(tgt_x), .target_y_o(tgt_y), .target_z_o(tgt_z),
    .up_x_o(up_x), .up_y_o(up_y), .up_z_o(up_z),
    .near_plane_o(near_pl), .far_plane_o(far_pl), .view_angle_o(fov),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // predictor state
  int  key_time_tab [MAXK];
  int  key_val_tab  [MAXK][12];
  int  peak_time, now_time, now_key, key_cnt;
  bit  cyc_on, rev_on;

  cam_t expected_cams [$];
  int   errors = 0;
  longint cycles = 0;
  int   burst_left = 0;
  int   stall_mode = 0, stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** keyframe_camera_interpolator: FAILED **");
      $finish;
    end
  end

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int used_keys();
    if (key_cnt < 1) return 1;
    if (key_cnt > MAXK) return MAXK;
    return key_cnt;
  endfunction

  function automatic int seq_len();
    return rev_on ? 2 * used_keys() : used_keys();
  endfunction

  function automatic int key_src(int k);
    int n;
    n = used_keys();
    return (k < n) ? k : 2 * n - 1 - k;
  endfunction

  function automatic longint key_at(int k);
    int n;
    n = used_keys();
    if (k < n) return key_time_tab[k];
    return sat(2 * longint'(peak_time) - key_time_tab[2 * n - 1 - k]);
  endfunction

  function automatic longint span_time();
    return rev_on ? sat(2 * longint'(peak_time)) : longint'(peak_time);
  endfunction

  function automatic void seek_key();
    longint tnow, span;
    int len;
    len  = seq_len();
    tnow = now_time;
    span = span_time();
    if (cyc_on && span > 0 && tnow > span) begin
      tnow     = ((tnow - 1) % span) + 1;
      now_time = int'(tnow);
      now_key  = 0;
    end
    if (now_key >= len) now_key = 0;
    while (now_key + 1 < len && tnow > key_at(now_key + 1)) now_key++;
  endfunction

  function automatic longint floor_frac(longint p);
    if (p >= 0) return p >>> FRAC;
    return -((-p + (ONE - 1)) >>> FRAC);
  endfunction

  function automatic cam_t camera_for(cmd_e c, logic signed [31:0] v);
    int len, nxt, ca, cb;
    longint t, tk, tn;
    longint r [12];
    cam_t o;
    case (c)
      CMD_ADVANCE: begin
        now_time = int'(sat(longint'(now_time) + longint'(v)));
        seek_key();
      end
      CMD_SET: begin
        now_time = v;
        now_key  = 0;
        seek_key();
      end
      default: begin
        now_time = 0;
        now_key  = 0;
      end
    endcase
    len = seq_len();
    if (now_key >= len) now_key = 0;
    nxt = (now_key + 1 < len) ? now_key + 1 : now_key;
    t = ONE;
    if (nxt != now_key) begin
      tk = key_at(now_key);
      tn = key_at(nxt);
      if (tn != tk) t = sat((longint'(now_time) - tk) * ONE / (tn - tk));
    end
    ca = key_src(now_key);
    cb = key_src(nxt);
    for (int i = 0; i < 12; i++) begin
      r[i] = sat(longint'(key_val_tab[ca][i]) +
                 floor_frac((longint'(key_val_tab[cb][i]) - key_val_tab[ca][i]) * t));
    end
    for (int i = 0; i < 3; i++) begin
      o[i]     = r[i][31:0];
      o[3 + i] = 32'(sat(r[6 + i] + r[i]));
      o[6 + i] = r[3 + i][31:0];
    end
    o[9]  = {1'b0, ((r[9] < NEAR_LOW) ? NEAR_LOW[30:0] : r[9][30:0])};
    o[10] = r[10][31:0];
    o[11] = r[11][31:0];
    return o;
  endfunction

  function automatic void store_key(logic [5:0] s, logic [3:0] ch, logic signed [31:0] v);
    if (ch > CHAN_LAST) return;
    if (ch == CHAN_TIME) begin
      key_time_tab[s] = v;
      if (v > peak_time) peak_time = v;
    end else begin
      key_val_tab[s][ch - 1] = v;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycles);
    errors++;
  endtask

  // send one input word; returns at the falling edge after acceptance, valid still high
  task automatic send_word(cmd_e c, logic [5:0] s, logic [3:0] ch, logic [31:0] v,
                           bit typed = 0, cam_t cam = '0);
    cam_t pred;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    cmd = c; key_slot = s; channel = ch; value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (c == CMD_LOAD) begin
      store_key(s, ch, v);
    end else begin
      pred = camera_for(c, v);
      expected_cams.insert(expected_cams.size(), typed ? cam : pred);
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_cams.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(reg_e idx, logic [6:0] d);
    wait_idle();
    cfg_index = idx; cfg_data = d; cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CYCLE:   cyc_on  = d[0];
      REG_REVERSE: rev_on  = d[0];
      default:     key_cnt = d;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
      3: return $urandom_range(0, 8 * 65536) - 4 * 65536;
      default: return $urandom;
    endcase
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 400);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= (stall_left % 37) < 3;
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    cam_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {fov, far_pl, {1'b0, near_pl}, up_z, up_y, up_x,
             tgt_z, tgt_y, tgt_x, pos_z, pos_y, pos_x};
      if (expected_cams.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, 32'h0);
      end else begin
        want = expected_cams.pop_front();
        for (int i = 0; i < 12; i++)
          if (want[i] !== got[i]) report_mismatch($sformatf("field %0d", i), want[i], got[i]);
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    cam_t c0;
    int n, spacing, phase_items;
    logic [31:0] tv;
    rst_n = 1'b0; in_valid = 1'b0; cfg_valid = 1'b0; out_ready = 1'b0;
    cmd = CMD_LOAD; key_slot = '0; channel = '0; value = '0;
    cfg_index = REG_CYCLE; cfg_data = '0;
    for (int k = 0; k < MAXK; k++) begin
      key_time_tab[k] = 0;
      for (int i = 0; i < 12; i++) key_val_tab[k][i] = 0;
    end
    peak_time = 0; now_time = 0; now_key = 0; key_cnt = 1; cyc_on = 0; rev_on = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // fill every key so no unwritten entry is ever read
    for (int k = 0; k < MAXK; k++)
      for (int ch = 0; ch <= CHAN_LAST; ch++)
        send_word(CMD_LOAD, 6'(k), 4'(ch), (ch == 0) ? 32'(k * 65536) : rand_value());

    c0 = {32'h12345678, 32'hffffffff, 32'd7, 32'h00030000, 32'h00020000, 32'h00010000,
          32'h00000005, 32'h80000000, 32'h7fffffff, 32'h0, 32'h80000000, 32'h7fffffff};
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd1, 32'h7fffffff, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd2, 32'h80000000, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd3, 32'h0, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd4, 32'h00010000, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd5, 32'h00020000, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd6, 32'h00030000, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd7, 32'h1, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd8, 32'hffffffff, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd9, 32'h5, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd10, 32'h0, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd11, 32'hffffffff, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd12, 32'h12345678, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd13, 32'h55555555, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd0, 4'd15, 32'haaaaaaaa, 0, '0});
    rows.insert(rows.size(), '{CMD_RESET, 6'd0, 4'd0, 32'h0, 1, c0});
    rows.insert(rows.size(), '{CMD_ADVANCE, 6'd63, 4'd15, 32'h7fffffff, 1, c0});
    rows.insert(rows.size(), '{CMD_ADVANCE, 6'd0, 4'd0, 32'h7fffffff, 1, c0});
    rows.insert(rows.size(), '{CMD_SET, 6'd0, 4'd0, 32'h80000000, 1, c0});
    rows.insert(rows.size(), '{CMD_ADVANCE, 6'd0, 4'd0, 32'h80000000, 1, c0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd63, 4'd0, 32'h7fffffff, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd63, 4'd0, 32'h80000000, 0, '0});
    rows.insert(rows.size(), '{CMD_SET, 6'd0, 4'd0, 32'h00008000, 0, '0});
    rows.insert(rows.size(), '{CMD_LOAD, 6'd63, 4'd0, 32'h003f0000, 0, '0});
    rows.insert(rows.size(), '{CMD_RESET, 6'd0, 4'd0, 32'hffffffff, 1, c0});
    foreach (rows[i])
      send_word(rows[i].cmd, rows[i].slot, rows[i].chan, rows[i].val, rows[i].typed, rows[i].cam);

    // hold off until every result has come back
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: n = 2;
        1: n = 64;
        2: n = 0;
        3: n = 127;
        default: n = $urandom_range(1, 8);
      endcase
      write_reg(REG_COUNT, 7'(n));
      write_reg(REG_CYCLE, 7'((ph == 0) ? 0 : (ph == 1) ? 1 : $urandom_range(0, 1)));
      write_reg(REG_REVERSE, 7'((ph == 2) ? 0 : (ph == 3) ? 1 : $urandom_range(0, 1)));
      n = used_keys();
      spacing = $urandom_range(1, 4) * 65536 + $urandom_range(0, 65535);
      for (int k = 0; k < n; k++)
        send_word(CMD_LOAD, 6'(k), CHAN_TIME, 32'((k == 1 && $urandom_range(0, 3) == 0) ?
                  (k - 1) * spacing : k * spacing));
      phase_items = (n > 16) ? 60 : 100;
      for (int j = 0; j < phase_items; j++) begin
        case ($urandom_range(0, 9))
          0, 1: send_word(CMD_LOAD, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 12)),
                          rand_value());
          2: send_word(CMD_LOAD, 6'($urandom), 4'($urandom), $urandom);
          3, 4, 5: send_word(CMD_ADVANCE, 6'($urandom), 4'($urandom),
                             32'($urandom_range(0, 2 * spacing)));
          6: send_word(CMD_ADVANCE, 6'($urandom), 4'($urandom), rand_value());
          7: begin
            tv = 32'($urandom_range(0, (n + 1) * spacing) - spacing / 2);
            send_word(CMD_SET, 6'($urandom), 4'($urandom),
                      ($urandom_range(0, 3) == 0) ? rand_value() : tv);
          end
          8: send_word(CMD_SET, 6'($urandom), 4'($urandom), 32'($urandom_range(0, n * spacing)));
          default: send_word(CMD_RESET, 6'($urandom), 4'($urandom), $urandom);
        endcase
      end
    end

    in_valid = 1'b0;
    while (expected_cams.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (errors == 0) begin
      $display("** keyframe_camera_interpolator: PASSED **");
    end else begin
      $display("** keyframe_camera_interpolator: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/kci_pkg.sv
rtl/kci_div.sv
rtl/kci_mul.sv
rtl/keyframe_camera_interpolator.sv
verif/testbench.sv
